[hdl/glc_pkg.sv]
// Package with the constants, register codes and coefficient functions of the gamma curve.
`default_nettype none

package glc_pkg;

   localparam int DAC_MAX    = 1023;
   localparam int MAX_LEVELS = 4096;

   localparam int LOG_STEPS = 16;
   localparam int EXP_STEPS = 16;
   localparam int DIV_STEPS = 24;

   typedef enum logic [1:0] {
      CSR_GAMMA = 2'd0,
      CSR_VZERO = 2'd1,
      CSR_COUNT = 2'd2
   } csr_index_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) begin
            r = t;
         end
      end
      return r;
   endfunction

   // Q30 value of 2 to the power 2^-(k+1).
   function automatic logic [30:0] exp2_coef(input int k);
      logic [63:0] c;
      c = isqrt64(64'd2 << 60);
      for (int i = 0; i < k; i++) begin
         c = isqrt64(c << 30);
      end
      return c[30:0];
   endfunction

endpackage

`default_nettype wire

[hdl/gamma_linearization_curve.sv]
// Top level of the gamma linearization curve: a pipelined log2, divide and exp2 datapath.
`default_nettype none

// One level index enters per cycle while the skid register is empty. The pipeline is made
// of the sixteen squaring stages of the logarithm, the twenty-four stages of the restoring
// divider by gamma and the sixteen multiply stages of the exponential, plus the entry,
// sign split, exponent split, shift, multiply and output registers. A stalled result beat
// is held in the output register and one more in a skid register, and the pipeline freezes
// only while the skid register is full. Configuration writes are always taken and must
// only be made while no beat is in flight.
module gamma_linearization_curve (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [11:0] req_level_index,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [15:0] rsp_dac_code,
   output      logic        rsp_out_of_range,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import glc_pkg::*;

   logic [15:0] gamma_ff;
   logic [15:0] vzero_ff;
   logic [12:0] count_ff;
   logic [15:0] gamma_eff;
   logic [12:0] count_eff;
   logic signed [16:0] span;
   logic        en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= 16'd10240;
         vzero_ff <= 16'd0;
         count_ff <= 13'd256;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GAMMA: gamma_ff <= csr_data;
            CSR_VZERO: vzero_ff <= csr_data;
            CSR_COUNT: count_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      gamma_eff = (gamma_ff < 16'd256) ? 16'd256 : gamma_ff;
      if (count_ff < 13'd2) begin
         count_eff = 13'd2;
      end else if (17'(count_ff) > 17'(MAX_LEVELS)) begin
         count_eff = 13'(MAX_LEVELS);
      end else begin
         count_eff = count_ff;
      end
      span = 17'(DAC_MAX) - $signed({1'b0, vzero_ff});
   end

   // Entry stage: leading one and Q30 mantissa of index and count.
   logic [3:0]  ei;
   logic [3:0]  ec;
   logic [30:0] mi_in;
   logic [30:0] mc_in;
   logic [12:0] xi;

   always_comb begin
      xi = {1'b0, req_level_index};
      ei = '0;
      ec = '0;
      for (int i = 0; i < 13; i++) begin
         if (xi[i]) begin
            ei = 4'(i);
         end
         if (count_eff[i]) begin
            ec = 4'(i);
         end
      end
      mi_in = 31'(xi) << (5'd30 - 5'(ei));
      mc_in = 31'(count_eff) << (5'd30 - 5'(ec));
   end

   logic        l_valid_ff [LOG_STEPS+1];
   logic        l_zero_ff  [LOG_STEPS+1];
   logic [30:0] l_mi_ff    [LOG_STEPS+1];
   logic [30:0] l_mc_ff    [LOG_STEPS+1];
   logic [19:0] l_ri_ff    [LOG_STEPS+1];
   logic [19:0] l_rc_ff    [LOG_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         l_valid_ff[0] <= 1'b0;
      end else if (en) begin
         l_valid_ff[0] <= req_valid;
         l_zero_ff[0]  <= (req_level_index == 12'd0);
         l_mi_ff[0]    <= mi_in;
         l_mc_ff[0]    <= mc_in;
         l_ri_ff[0]    <= {ei, 16'd0};
         l_rc_ff[0]    <= {ec, 16'd0};
      end
   end

   for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
      localparam int Bit = LOG_STEPS - 1 - j;
      logic [61:0] sqi;
      logic [61:0] sqc;
      logic [31:0] m2i;
      logic [31:0] m2c;

      always_comb begin
         sqi = 62'(l_mi_ff[j]) * 62'(l_mi_ff[j]);
         sqc = 62'(l_mc_ff[j]) * 62'(l_mc_ff[j]);
         m2i = sqi[61:30];
         m2c = sqc[61:30];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            l_valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            l_valid_ff[j+1] <= l_valid_ff[j];
            l_zero_ff[j+1]  <= l_zero_ff[j];
            l_mi_ff[j+1]    <= m2i[31] ? m2i[31:1] : m2i[30:0];
            l_mc_ff[j+1]    <= m2c[31] ? m2c[31:1] : m2c[30:0];
            l_ri_ff[j+1]    <= l_ri_ff[j] | (20'(m2i[31]) << Bit);
            l_rc_ff[j+1]    <= l_rc_ff[j] | (20'(m2c[31]) << Bit);
         end
      end
   end

   // Difference of the logarithms, split into sign and magnitude for the divider.
   logic signed [20:0] d;
   logic [19:0]        dmag;

   always_comb begin
      d    = $signed({1'b0, l_ri_ff[LOG_STEPS]}) - $signed({1'b0, l_rc_ff[LOG_STEPS]});
      dmag = d[20] ? 20'(-d) : d[19:0];
   end

   logic        v_valid_ff [DIV_STEPS+1];
   logic        v_zero_ff  [DIV_STEPS+1];
   logic        v_neg_ff   [DIV_STEPS+1];
   logic [31:0] v_rem_ff   [DIV_STEPS+1];
   logic [23:0] v_quo_ff   [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff[0] <= 1'b0;
      end else if (en) begin
         v_valid_ff[0] <= l_valid_ff[LOG_STEPS];
         v_zero_ff[0]  <= l_zero_ff[LOG_STEPS];
         v_neg_ff[0]   <= d[20];
         v_rem_ff[0]   <= {dmag, 12'd0};
         v_quo_ff[0]   <= '0;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int Bit = DIV_STEPS - 1 - j;
      logic [39:0] dsh;
      logic        take;

      always_comb begin
         dsh  = 40'(gamma_eff) << Bit;
         take = (40'(v_rem_ff[j]) >= dsh);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            v_valid_ff[j+1] <= v_valid_ff[j];
            v_zero_ff[j+1]  <= v_zero_ff[j];
            v_neg_ff[j+1]   <= v_neg_ff[j];
            v_rem_ff[j+1]   <= take ? 32'(40'(v_rem_ff[j]) - dsh) : v_rem_ff[j];
            v_quo_ff[j+1]   <= v_quo_ff[j] | (24'(take) << Bit);
         end
      end
   end

   // Signed quotient, split into integer and fraction of the exponent.
   logic signed [24:0] y;
   logic signed [8:0]  n;
   logic signed [8:0]  ncap;

   always_comb begin
      y    = v_neg_ff[DIV_STEPS] ? -$signed({1'b0, v_quo_ff[DIV_STEPS]})
                                 : $signed({1'b0, v_quo_ff[DIV_STEPS]});
      n    = y[24:16];
      ncap = (n > 9'sd16) ? 9'sd16 : n;
   end

   logic              e_valid_ff [EXP_STEPS+1];
   logic              e_zero_ff  [EXP_STEPS+1];
   logic signed [8:0] e_n_ff     [EXP_STEPS+1];
   logic [15:0]       e_f_ff     [EXP_STEPS+1];
   logic [30:0]       e_acc_ff   [EXP_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff[0] <= 1'b0;
      end else if (en) begin
         e_valid_ff[0] <= v_valid_ff[DIV_STEPS];
         e_zero_ff[0]  <= v_zero_ff[DIV_STEPS];
         e_n_ff[0]     <= ncap;
         e_f_ff[0]     <= y[15:0];
         e_acc_ff[0]   <= 31'd1 << 30;
      end
   end

   for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
      localparam logic [30:0] Coef = exp2_coef(k);
      logic [61:0] prod;

      assign prod = 62'(e_acc_ff[k]) * 62'(Coef);

      always_ff @(posedge clock) begin
         if (reset) begin
            e_valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            e_valid_ff[k+1] <= e_valid_ff[k];
            e_zero_ff[k+1]  <= e_zero_ff[k];
            e_n_ff[k+1]     <= e_n_ff[k];
            e_f_ff[k+1]     <= e_f_ff[k];
            e_acc_ff[k+1]   <= e_f_ff[k][EXP_STEPS-1-k] ? prod[60:30] : e_acc_ff[k];
         end
      end
   end

   // Scale by the integer part: right shifts here, left shifts after the multiply.
   logic signed [9:0] rsh;
   logic [30:0]       pbase_in;
   logic [1:0]        lsh_in;
   logic              s_valid_ff;
   logic              s_zero_ff;
   logic [30:0]       s_pbase_ff;
   logic [1:0]        s_lsh_ff;

   always_comb begin
      rsh = 10'sd14 - {e_n_ff[EXP_STEPS][8], e_n_ff[EXP_STEPS]};
      if (e_n_ff[EXP_STEPS] <= 9'sd14) begin
         pbase_in = (rsh >= 10'sd31) ? 31'd0 : (e_acc_ff[EXP_STEPS] >> rsh[4:0]);
         lsh_in   = 2'd0;
      end else begin
         pbase_in = e_acc_ff[EXP_STEPS];
         lsh_in   = 2'(e_n_ff[EXP_STEPS] - 9'sd14);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (en) begin
         s_valid_ff <= e_valid_ff[EXP_STEPS];
         s_zero_ff  <= e_zero_ff[EXP_STEPS];
         s_pbase_ff <= pbase_in;
         s_lsh_ff   <= lsh_in;
      end
   end

   logic               m_valid_ff;
   logic               m_zero_ff;
   logic signed [48:0] m_prod_ff;
   logic [1:0]         m_lsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= s_valid_ff;
         m_zero_ff  <= s_zero_ff;
         m_prod_ff  <= 49'(span) * $signed({1'b0, s_pbase_ff});
         m_lsh_ff   <= s_lsh_ff;
      end
   end

   // Offset, clamp at zero and saturate.
   logic signed [50:0] scaled;
   logic signed [51:0] total;
   logic [35:0]        code;
   logic [15:0]        fin_dac;
   logic               fin_oor;

   always_comb begin
      scaled = {{2{m_prod_ff[48]}}, m_prod_ff} <<< m_lsh_ff;
      total  = $signed({20'd0, vzero_ff, 16'd0}) + {scaled[50], scaled};
      code   = total[51] ? 36'd0 : total[51:16];
      if (m_zero_ff) begin
         fin_dac = '0;
         fin_oor = 1'b0;
      end else begin
         fin_oor = (code > 36'(DAC_MAX));
         fin_dac = (code[35:16] != 20'd0) ? 16'hFFFF : code[15:0];
      end
   end

   logic        rsp_valid_ff;
   logic [15:0] rsp_dac_ff;
   logic        rsp_oor_ff;
   logic        skid_valid_ff;
   logic [15:0] skid_dac_ff;
   logic        skid_oor_ff;

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            rsp_dac_ff    <= skid_dac_ff;
            rsp_oor_ff    <= skid_oor_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= m_valid_ff;
         rsp_dac_ff   <= fin_dac;
         rsp_oor_ff   <= fin_oor;
      end else if (m_valid_ff) begin
         skid_valid_ff <= 1'b1;
         skid_dac_ff   <= fin_dac;
         skid_oor_ff   <= fin_oor;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dac_code     = rsp_dac_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a beat while the output register is empty");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      v_valid_ff[DIV_STEPS] |-> (v_rem_ff[DIV_STEPS] < 32'(gamma_eff)))
      else $error("divider remainder not below the divisor");

   a_flag_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_oor_ff |-> (17'(rsp_dac_ff) > 17'(DAC_MAX)) || (rsp_dac_ff == 16'hFFFF))
      else $error("out of range flag set on a code within range");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(m_prod_ff) || !$past(m_valid_ff))
      else $error("pipeline moved while the skid register was full");

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the gamma linearization curve with its own fixed-point predictor.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
   import glc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [11:0] req_level_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_dac_code;
   logic        rsp_out_of_range;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   typedef struct packed {
      logic [15:0] code;
      logic        oor;
   } code_beat_type;

   code_beat_type pending_codes[$];
   logic [15:0] cur_gamma = 16'd10240;
   logic [15:0] cur_vzero = 16'd0;
   logic [12:0] cur_count = 13'd256;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_off = 1'b0;
   int          errors = 0;
   int          quiet_cycles = 0;

   localparam int QUIET_LIMIT = 20000;

   gamma_linearization_curve DUT (.*);

   always #2 clock = ~clock;

   function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic longint log2_fix(input longint x);
      int          e;
      logic [63:0] m;
      longint      res;
      e = 0;
      while (e < 40 && (x >> (e + 1)) != 0) e++;
      m = 64'(x) << (30 - e);
      res = longint'(e) << 16;
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd2 << 30)) begin
            res |= longint'(1) << i;
            m >>= 1;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] exp2_frac(input logic [15:0] f);
      logic [63:0] acc;
      logic [63:0] c;
      acc = 64'd1 << 30;
      c = sqrt_floor(64'd2 << 60);
      for (int k = 0; k < 16; k++) begin
         if (f[15 - k]) acc = (acc * c) >> 30;
         c = sqrt_floor(c << 30);
      end
      return acc;
   endfunction

   function automatic code_beat_type predict_code(input logic [11:0] idx);
      code_beat_type r;
      longint      cnt, g, d, y, n, f, p, span, total, code;
      logic [63:0] p30;
      r = '0;
      if (idx == 0) return r;
      cnt = cur_count;
      g = cur_gamma;
      if (cnt < 2) cnt = 2;
      if (cnt > MAX_LEVELS) cnt = MAX_LEVELS;
      if (g < 256) g = 256;
      d = log2_fix(idx) - log2_fix(cnt);
      y = (d * 4096) / g;
      if (y >= 0) n = y / 65536;
      else n = -((-y + 65535) / 65536);
      f = y - n * 65536;
      if (n > 16) n = 16;
      p30 = exp2_frac(16'(f));
      if (n <= 14) p = (14 - n >= 64) ? 0 : longint'(p30 >> (14 - n));
      else p = longint'(p30 << (n - 14));
      span = longint'(DAC_MAX) - longint'(cur_vzero);
      total = longint'(cur_vzero) * 65536 + span * p;
      code = (total < 0) ? 0 : total / 65536;
      r.oor = code > DAC_MAX;
      r.code = (code > 65535) ? 16'hFFFF : 16'(code);
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      code_beat_type exp_beat;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            $error("Unexpected result beat: dac_code %0d", rsp_dac_code);
            errors++;
         end else begin
            exp_beat = pending_codes.pop_front();
            if (rsp_dac_code !== exp_beat.code) begin
               $error("dac_code: expected %0d, actual %0d", exp_beat.code, rsp_dac_code);
               errors++;
            end
            if (rsp_out_of_range !== exp_beat.oor) begin
               $error("out_of_range: expected %0d, actual %0d", exp_beat.oor, rsp_out_of_range);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_level(input logic [11:0] idx);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_level_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_codes.push_back(predict_code(idx));
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type which, input logic [15:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (which)
         CSR_GAMMA: cur_gamma = value;
         CSR_VZERO: cur_vzero = value;
         default: cur_count = value[12:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_curve(input logic [15:0] g, input logic [15:0] v, input logic [15:0] c);
      write_csr(CSR_GAMMA, g);
      write_csr(CSR_VZERO, v);
      write_csr(CSR_COUNT, c);
   endtask

   task automatic test_directed;
      logic [11:0] lv[] = '{0, 1, 2, 255, 256, 4095, 128, 2048, 12'hAAA, 12'h555};
      foreach (lv[i]) send_level(lv[i]);
      set_curve(16'd256, 16'd2000, 16'd0);
      send_level(12'd0);
      send_level(12'd1);
      send_level(12'd4095);
      set_curve(16'hFFFF, 16'hFFFF, 16'h1FFF);
      send_level(12'd1);
      send_level(12'd4095);
      set_curve(16'd100, 16'd0, 16'd2);
      send_level(12'd1);
      send_level(12'd3);
      send_level(12'd4095);
      set_curve(16'd4096, 16'd100, 16'd4096);
      send_level(12'd1);
      send_level(12'd4095);
   endtask

   task automatic test_random(input int items, input int idle, input int stall);
      logic [11:0] idx;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      set_curve(16'($urandom_range(65535, 256)),
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1023)),
                16'($urandom_range(4096, 2)));
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(3) == 0) idx = 12'($urandom);
         else idx = 12'($urandom_range(cur_count > 1 ? cur_count - 1 : 1));
         send_level(idx);
      end
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 120; i++) send_level(12'($urandom));
      join
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(80, 0, 0);
      test_random(80, 75, 0);
      test_random(80, 0, 75);
      test_random(80, 17, 17);
      test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
